// ----- hw/rtl/dmt_pkg.sv -----
`default_nettype none

package dmt_pkg;

    // Motor count and bit timer width
    localparam int NUM_MOTORS  = 4;
    localparam int COUNT_WIDTH = 16;

    // Only four motors have throttle fields and lines
    localparam int LINES = (NUM_MOTORS > 4) ? 4 : NUM_MOTORS;
    localparam logic [3:0] LINE_MASK = 4'((1 << LINES) - 1);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // Width used to compare the counter against a phase length
    localparam int CMP_W = (COUNT_WIDTH + 1 > 17) ? COUNT_WIDTH + 1 : 17;

    localparam int THR_W  = 16;
    localparam int VAL_W  = 11;
    localparam int WORD_W = 16;
    localparam int LEN_W  = 16;
    localparam int CMD_W  = 6;

    // Throttle mapping constants
    localparam logic [VAL_W-1:0] COEF_3D     = 11'd999;
    localparam logic [VAL_W-1:0] COEF_NORMAL = 11'd1999;
    localparam logic [VAL_W:0]   BASE_LOW    = 12'd48;
    localparam logic [VAL_W:0]   BASE_3D_FWD = 12'd1048;
    localparam logic [VAL_W:0]   VAL_LIMIT   = 12'd2048;

    // Item operation codes
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_THROTTLE = 2'd1;
    localparam logic [1:0] OP_COMMAND  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_THREE_D_MODE      = 2'd0;
    localparam logic [1:0] REG_LOW_CYCLES        = 2'd1;
    localparam logic [1:0] REG_ZERO_HIGH_CYCLES  = 2'd2;
    localparam logic [1:0] REG_EXTRA_HIGH_CYCLES = 2'd3;

    typedef enum logic [1:0] {
        PH_LOW  = 2'd0,
        PH_HIGH = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef struct packed {
        logic             three_d_mode;
        logic [LEN_W-1:0] low_cycles;
        logic [LEN_W-1:0] zero_high_cycles;
        logic [LEN_W-1:0] extra_high_cycles;
    } cfg_t;

    // Classified item carried from the front end to the serializer
    typedef struct packed {
        logic [1:0]            op;
        logic [3:0][VAL_W-1:0] scaled;
        logic [3:0]            neg;
        logic [CMD_W-1:0]      command;
        logic                  telemetry;
    } item_t;

    function automatic logic [VAL_W-1:0] map_value(
        input logic [VAL_W-1:0] scaled,
        input logic             neg,
        input logic             three_d
    );
        logic [VAL_W:0] sum;
        if (three_d) begin
            sum = (neg ? BASE_LOW : BASE_3D_FWD) + {1'b0, scaled};
        end else if (neg) begin
            sum = '0;
        end else begin
            sum = BASE_LOW + {1'b0, scaled};
        end
        if (sum < BASE_LOW || sum >= VAL_LIMIT) begin
            sum = '0;
        end
        return sum[VAL_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] make_word(
        input logic [VAL_W-1:0] value,
        input logic             tel
    );
        logic [VAL_W:0] p;
        logic [3:0]     cs;
        p  = {value, tel};
        cs = p[3:0] ^ p[7:4] ^ p[11:8];
        return {p, cs};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/dmt_if.sv -----
`default_nettype none

interface dmt_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            op;
    logic signed [dmt_pkg::THR_W-1:0]      throttle_0;
    logic signed [dmt_pkg::THR_W-1:0]      throttle_1;
    logic signed [dmt_pkg::THR_W-1:0]      throttle_2;
    logic signed [dmt_pkg::THR_W-1:0]      throttle_3;
    logic [dmt_pkg::CMD_W-1:0]             command;
    logic                                  telemetry;

    modport source (
        output valid, op, throttle_0, throttle_1, throttle_2, throttle_3, command, telemetry,
        input  ready
    );
    modport sink (
        input  valid, op, throttle_0, throttle_1, throttle_2, throttle_3, command, telemetry,
        output ready
    );
endinterface

interface dmt_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] pin_levels;
    logic       busy_res;
    logic       accepted;
    logic       frame_done;

    modport source (
        output valid, pin_levels, busy_res, accepted, frame_done,
        input  ready
    );
    modport sink (
        input  valid, pin_levels, busy_res, accepted, frame_done,
        output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/dshot_multi_motor_transmitter_core.sv -----
`default_nettype none

// Channel  Role  Handshake            Payload
// req      sink  req.valid/req.ready  op, throttle_0..3, command, telemetry
// rsp      src   rsp.valid/rsp.ready  pin_levels, busy_res, accepted, frame_done
// cfg      in    cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One item per clock sustained while rsp is ready; a result is registered in turn
// by the front-end register, the two-entry queue and the serializer output register.
// The throttle multipliers sit in the front end; the serializer does one bit-timer
// step or one frame load per cycle while rsp is not stalled.
// rst_n clears all control state and the configuration to its defaults.
// A stall on rsp backs up the queue; req keeps accepting until the queue fills.

module dshot_multi_motor_transmitter_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dmt_in_if.sink                             req,
    dmt_out_if.source                          rsp,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [dmt_pkg::LEN_W-1:0]     cfg_data
);

    dmt_pkg::cfg_t  cfg_reg;

    logic           front_valid;
    logic           front_ready;
    dmt_pkg::item_t front_item;
    logic           queue_valid;
    logic           queue_ready;
    dmt_pkg::item_t queue_item;

    // Config registers; written by user only while pipeline drained; unchecked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.three_d_mode      <= 1'b0;
            cfg_reg.low_cycles        <= 16'd177;
            cfg_reg.zero_high_cycles  <= 16'd177;
            cfg_reg.extra_high_cycles <= 16'd177;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dmt_pkg::REG_THREE_D_MODE:      cfg_reg.three_d_mode      <= cfg_data[0];
                dmt_pkg::REG_LOW_CYCLES:        cfg_reg.low_cycles        <= cfg_data;
                dmt_pkg::REG_ZERO_HIGH_CYCLES:  cfg_reg.zero_high_cycles  <= cfg_data;
                dmt_pkg::REG_EXTRA_HIGH_CYCLES: cfg_reg.extra_high_cycles <= cfg_data;
                default:                        cfg_reg.three_d_mode      <= cfg_reg.three_d_mode;
            endcase
        end
    end

    // Front end: capture the transfer and scale the throttles
    dmt_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .three_d_mode (cfg_reg.three_d_mode),
        .req          (req),
        .item_valid   (front_valid),
        .item_ready   (front_ready),
        .item         (front_item)
    );

    // Queue decouples the front end from serializer stalls
    dmt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_item   (queue_item)
    );

    // Back end: build frames, advance the bit timer, drive the result
    dmt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item_ready (queue_ready),
        .item       (queue_item),
        .rsp        (rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/dmt_front.sv -----
`default_nettype none

module dmt_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           three_d_mode,
    dmt_in_if.sink              req,
    output logic                item_valid,
    input  wire logic           item_ready,
    output dmt_pkg::item_t      item
);

    logic                                 valid_reg;
    dmt_pkg::item_t                       item_reg;
    dmt_pkg::item_t                       item_next;
    logic [3:0][dmt_pkg::THR_W-1:0]       thr;
    logic [dmt_pkg::THR_W-1:0]            mag;
    logic [dmt_pkg::THR_W+dmt_pkg::VAL_W-1:0] prod;
    logic [dmt_pkg::VAL_W-1:0]            coef;
    logic                                 take;

    assign req.ready  = !valid_reg || item_ready;
    assign take       = req.valid && req.ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // Scale each throttle magnitude; the add and range check happen downstream
    always_comb
    begin
        thr  = {req.throttle_3, req.throttle_2, req.throttle_1, req.throttle_0};
        coef = three_d_mode ? dmt_pkg::COEF_3D : dmt_pkg::COEF_NORMAL;
        item_next.op        = req.op;
        item_next.command   = req.command;
        item_next.telemetry = req.telemetry;
        mag  = '0;
        prod = '0;
        for (int i = 0; i < 4; i++)
        begin
            item_next.neg[i]    = thr[i][dmt_pkg::THR_W-1];
            mag                 = thr[i][dmt_pkg::THR_W-1] ? (~thr[i] + 16'd1) : thr[i];
            prod                = {11'd0, mag} * {16'd0, coef};
            item_next.scaled[i] = prod[dmt_pkg::THR_W+dmt_pkg::VAL_W-2:dmt_pkg::THR_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (item_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmt_queue.sv -----
`default_nettype none

module dmt_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    output logic                push_ready,
    input  wire dmt_pkg::item_t push_item,
    output logic                pop_valid,
    input  wire logic           pop_ready,
    output dmt_pkg::item_t      pop_item
);

    dmt_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic           push;
    logic           pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/dmt_back.sv -----
`default_nettype none

module dmt_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire dmt_pkg::cfg_t  cfg,
    input  wire logic           item_valid,
    output logic                item_ready,
    input  wire dmt_pkg::item_t item,
    dmt_out_if.source           rsp
);

    logic [3:0][dmt_pkg::WORD_W-1:0]  words_reg, words_next;
    logic [3:0]                       bit_reg, bit_next;
    dmt_pkg::phase_t                  phase_reg, phase_next;
    logic [dmt_pkg::COUNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic                             active_reg, active_next;
    logic [3:0]                       lines_reg, lines_next;
    logic                             acc_next, done_next;

    logic                             rsp_valid_reg;
    logic [3:0]                       pin_reg;
    logic                             busy_reg, acc_reg, done_reg;

    logic                             take;
    logic [dmt_pkg::LEN_W-1:0]        len;
    logic [dmt_pkg::COUNT_WIDTH:0]    cnt_inc;
    logic                             phase_end;
    logic [3:0]                       level;
    logic [dmt_pkg::VAL_W-1:0]        val;

    assign item_ready     = !rsp_valid_reg || rsp.ready;
    assign take           = item_valid && item_ready;
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.pin_levels = pin_reg;
    assign rsp.busy_res   = busy_reg;
    assign rsp.accepted   = acc_reg;
    assign rsp.frame_done = done_reg;

    always_comb
    begin
        case (phase_reg)
            dmt_pkg::PH_LOW:  len = cfg.low_cycles;
            dmt_pkg::PH_HIGH: len = cfg.zero_high_cycles;
            default:          len = cfg.extra_high_cycles;
        endcase
        cnt_inc   = {1'b0, cnt_reg} + {{dmt_pkg::COUNT_WIDTH{1'b0}}, 1'b1};
        phase_end = (dmt_pkg::CMP_W'(cnt_inc) >= dmt_pkg::CMP_W'(len))
                    || (cnt_reg == dmt_pkg::CNT_MAX);

        level = '0;
        case (phase_reg)
            dmt_pkg::PH_LOW:  level = '0;
            dmt_pkg::PH_HIGH: level = dmt_pkg::LINE_MASK;
            default:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    level[i] = words_reg[i][~bit_reg];
                end
                level = level & dmt_pkg::LINE_MASK;
            end
        endcase

        words_next  = words_reg;
        bit_next    = bit_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        lines_next  = lines_reg;
        acc_next    = 1'b0;
        done_next   = 1'b0;
        val         = '0;

        case (item.op)
            dmt_pkg::OP_THROTTLE, dmt_pkg::OP_COMMAND:
            begin
                if (!active_reg)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        if (item.op == dmt_pkg::OP_THROTTLE)
                        begin
                            val = dmt_pkg::map_value(item.scaled[i], item.neg[i],
                                                     cfg.three_d_mode);
                            words_next[i] = dmt_pkg::make_word(val, 1'b0);
                        end
                        else
                        begin
                            words_next[i] = dmt_pkg::make_word(
                                {5'd0, item.command}, item.telemetry);
                        end
                    end
                    bit_next    = '0;
                    phase_next  = dmt_pkg::PH_LOW;
                    cnt_next    = '0;
                    active_next = 1'b1;
                    acc_next    = 1'b1;
                end
            end
            dmt_pkg::OP_TICK:
            begin
                if (active_reg)
                begin
                    lines_next = level;
                    if (phase_end)
                    begin
                        cnt_next = '0;
                        if (phase_reg == dmt_pkg::PH_DATA)
                        begin
                            phase_next = dmt_pkg::PH_LOW;
                            if (bit_reg == 4'd15)
                            begin
                                bit_next    = '0;
                                active_next = 1'b0;
                                done_next   = 1'b1;
                                lines_next  = '0;
                            end
                            else
                            begin
                                bit_next = bit_reg + 4'd1;
                            end
                        end
                        else if (phase_reg == dmt_pkg::PH_LOW)
                        begin
                            phase_next = dmt_pkg::PH_HIGH;
                        end
                        else
                        begin
                            phase_next = dmt_pkg::PH_DATA;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc[dmt_pkg::COUNT_WIDTH-1:0];
                    end
                end
                else
                begin
                    lines_next = '0;
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg     <= '0;
            bit_reg       <= '0;
            phase_reg     <= dmt_pkg::PH_LOW;
            cnt_reg       <= '0;
            active_reg    <= 1'b0;
            lines_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                words_reg     <= words_next;
                bit_reg       <= bit_next;
                phase_reg     <= phase_next;
                cnt_reg       <= cnt_next;
                active_reg    <= active_next;
                lines_reg     <= lines_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pin_reg  <= lines_next;
            busy_reg <= active_next;
            acc_reg  <= acc_next;
            done_reg <= done_next;
        end
    end

    // Idle serializer keeps all lines low and its position cleared
    a_idle_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (lines_reg == 4'd0))
        else $error("lines driven while idle");

    a_idle_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (bit_reg == 4'd0 && phase_reg == dmt_pkg::PH_LOW && cnt_reg == '0))
        else $error("bit position not cleared while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (take && acc_next) |=> (active_reg && rsp.busy_res && rsp.accepted))
        else $error("accepted send did not start a frame");

    a_done_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && done_reg) |-> (!busy_reg && pin_reg == 4'd0 && !acc_reg))
        else $error("frame end with lines or busy still set");

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import dmt_pkg::*;

    // Op value 3 has no name in the package; the block ignores it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One input item as the request channel carries it.
    typedef struct packed {
        logic [1:0]       op;
        logic [3:0][15:0] thr;
        logic [5:0]       command;
        logic             telemetry;
    } dshot_req_t;

    // One result: line levels and status after an item.
    typedef struct packed {
        logic [3:0] pin_levels;
        logic       busy_res;
        logic       accepted;
        logic       frame_done;
    } line_state_t;

    localparam line_state_t RSP_NONE    = '0;
    localparam line_state_t RSP_IDLE    = '{4'h0, 1'b0, 1'b0, 1'b0};
    localparam line_state_t RSP_LOADED  = '{4'h0, 1'b1, 1'b1, 1'b0};
    localparam line_state_t RSP_REFUSED = '{4'h0, 1'b1, 1'b0, 1'b0};

    typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

    // Directed stimulus row. A ROW_CFG row carries the 3D flag in thr0[0] and the
    // low, zero-high and extra-high lengths in thr1..thr3. The want column holds
    // for rows with typed set; every other row is checked against the predictor.
    typedef struct packed {
        row_kind_t   kind;
        logic [15:0] reps;
        logic [1:0]  op;
        logic [15:0] thr0;
        logic [15:0] thr1;
        logic [15:0] thr2;
        logic [15:0] thr3;
        logic [5:0]  command;
        logic        telemetry;
        logic        typed;
        line_state_t want;
    } row_t;

    row_t plan [0:20] = '{
        // tick and unused op right out of reset: lines low, nothing busy
        '{ROW_ITEM, 16'd1,  OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b1, RSP_IDLE},
        '{ROW_ITEM, 16'd1,  OP_UNUSED,   16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001,
          6'd63, 1'b1, 1'b1, RSP_IDLE},
        // all phase lengths zero: each acts as one tick
        '{ROW_CFG,  16'd1,  OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_THROTTLE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0030,
          6'd0,  1'b1, 1'b1, RSP_LOADED},
        // send while busy is refused
        '{ROW_ITEM, 16'd1,  OP_COMMAND,  16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd5,  1'b1, 1'b1, RSP_REFUSED},
        '{ROW_ITEM, 16'd20, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        // refused send and unused op mid-frame must not advance the bit timer
        '{ROW_ITEM, 16'd1,  OP_THROTTLE, 16'h1234, 16'h4321, 16'h0F0F, 16'hF0F0,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_UNUSED,   16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd28, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b1, RSP_IDLE},
        // command frames: lowest code, highest legal code, a code past 47
        '{ROW_ITEM, 16'd1,  OP_COMMAND,  16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b1, 1'b1, RSP_LOADED},
        '{ROW_ITEM, 16'd48, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_COMMAND,  16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd47, 1'b0, 1'b1, RSP_LOADED},
        '{ROW_ITEM, 16'd48, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_COMMAND,  16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd63, 1'b1, 1'b1, RSP_LOADED},
        '{ROW_ITEM, 16'd48, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        // 3D mapping, uneven phase lengths
        '{ROW_CFG,  16'd1,  OP_TICK,     16'h0001, 16'h0001, 16'h0002, 16'h0001,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_THROTTLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000,
          6'd0,  1'b1, 1'b1, RSP_LOADED},
        '{ROW_ITEM, 16'd64, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE},
        '{ROW_ITEM, 16'd1,  OP_THROTTLE, 16'h4000, 16'hC000, 16'h0001, 16'hFF00,
          6'd0,  1'b0, 1'b1, RSP_LOADED},
        '{ROW_ITEM, 16'd64, OP_TICK,     16'h0000, 16'h0000, 16'h0000, 16'h0000,
          6'd0,  1'b0, 1'b0, RSP_NONE}
    };

    logic clk;
    logic rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    dmt_in_if  req_if ();
    dmt_out_if rsp_if ();

    dshot_multi_motor_transmitter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_if),
        .rsp       (rsp_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the configuration registers
    logic        mode_3d;
    logic [15:0] len_low;
    logic [15:0] len_high;
    logic [15:0] len_extra;

    // Predictor copy of the transmitter state
    logic [15:0] tx_words [4];
    logic [3:0]  tx_bit;
    phase_t      tx_phase;
    logic [15:0] tx_count;
    logic        tx_busy;
    logic [3:0]  tx_lines;

    // Line states owed by the block, oldest first
    line_state_t owed_line_states [$];

    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_request;
    int fail_count;
    int items_in;
    int frames_sent;
    int sends_refused;

    // Map a Q1.15 throttle to the 11-bit DShot value.
    function automatic logic [10:0] scale_throttle(input logic signed [15:0] thr);
        int v;
        int val;
        v = thr;
        if (mode_3d) begin
            if (v >= 0)
                val = 1048 + ((v * 999) >> 15);
            else
                val = 48 + (((-v) * 999) >> 15);
        end
        else begin
            if (v < 0)
                return '0;
            val = 48 + ((v * 1999) >> 15);
        end
        if (val < 48 || val >= 2048)
            val = 0;
        return 11'(val);
    endfunction

    // Value, telemetry bit, then XOR of the three nibbles above.
    function automatic logic [15:0] dshot_word(input logic [10:0] value, input logic tel);
        logic [11:0] packed_bits;
        packed_bits = {value, tel};
        return {packed_bits, packed_bits[3:0] ^ packed_bits[7:4] ^ packed_bits[11:8]};
    endfunction

    // Advance the predictor by one accepted item; return the line state it causes.
    function automatic line_state_t next_line_state(input dshot_req_t it);
        line_state_t res;
        int          plen;
        logic [3:0]  lv;
        res = '0;
        if (it.op == OP_THROTTLE || it.op == OP_COMMAND) begin
            if (!tx_busy) begin
                for (int m = 0; m < 4; m++)
                    tx_words[m] = (it.op == OP_THROTTLE)
                                  ? dshot_word(scale_throttle(it.thr[m]), 1'b0)
                                  : dshot_word({5'd0, it.command}, it.telemetry);
                tx_bit   = '0;
                tx_phase = PH_LOW;
                tx_count = '0;
                tx_busy  = 1'b1;
                res.accepted = 1'b1;
            end
            else begin
                sends_refused++;
            end
        end
        else if (it.op == OP_TICK) begin
            if (tx_busy) begin
                case (tx_phase)
                    PH_LOW:  plen = len_low;
                    PH_HIGH: plen = len_high;
                    default: plen = len_extra;
                endcase
                if (plen == 0)
                    plen = 1;
                lv = '0;
                if (tx_phase == PH_HIGH)
                    lv = LINE_MASK;
                else if (tx_phase == PH_DATA)
                    for (int m = 0; m < LINES; m++)
                        lv[m] = tx_words[m][4'd15 - tx_bit];
                tx_lines = lv & LINE_MASK;
                if (int'(tx_count) + 1 >= plen || tx_count == CNT_MAX) begin
                    tx_count = '0;
                    case (tx_phase)
                        PH_LOW:  tx_phase = PH_HIGH;
                        PH_HIGH: tx_phase = PH_DATA;
                        default:
                        begin
                            tx_phase = PH_LOW;
                            if (tx_bit == 4'd15) begin
                                tx_bit   = '0;
                                tx_busy  = 1'b0;
                                tx_lines = '0;
                                res.frame_done = 1'b1;
                                frames_sent++;
                            end
                            else begin
                                tx_bit = tx_bit + 4'd1;
                            end
                        end
                    endcase
                end
                else begin
                    tx_count = tx_count + 16'd1;
                end
            end
            else begin
                tx_lines = '0;
            end
        end
        res.pin_levels = tx_lines;
        res.busy_res   = tx_busy;
        return res;
    endfunction

    // Random item for the given op; throttles lean toward the corners.
    function automatic dshot_req_t random_item(input logic [1:0] op);
        dshot_req_t it;
        it.op = op;
        for (int m = 0; m < 4; m++)
            case ($urandom_range(6))
                0:       it.thr[m] = 16'h7FFF;
                1:       it.thr[m] = 16'h8000;
                2:       it.thr[m] = 16'h0000;
                3:       it.thr[m] = 16'hFFFF;
                4:       it.thr[m] = 16'($urandom_range(64)) - 16'd32;
                default: it.thr[m] = 16'($urandom);
            endcase
        it.command   = 6'($urandom);
        it.telemetry = 1'($urandom);
        return it;
    endfunction

    // Short phase lengths keep frames brief; zero shows up now and then.
    function automatic logic [15:0] pick_len();
        return ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
    endfunction

    // Offer one item, hold it until the transfer, then record what it owes.
    task automatic offer_item(input dshot_req_t it, input bit typed, input line_state_t want);
        line_state_t predicted;
        while ($urandom_range(99) < snd_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.op         <= it.op;
        req_if.throttle_0 <= it.thr[0];
        req_if.throttle_1 <= it.thr[1];
        req_if.throttle_2 <= it.thr[2];
        req_if.throttle_3 <= it.thr[3];
        req_if.command    <= it.command;
        req_if.telemetry  <= it.telemetry;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predicted = next_line_state(it);
        owed_line_states.push_back(typed ? want : predicted);
        items_in++;
    endtask

    // Drop valid, let every owed result drain, then write all four registers.
    task automatic program_timing(input logic use_3d, input logic [15:0] lo,
                                  input logic [15:0] hi, input logic [15:0] ex);
        logic [15:0] vals [4];
        logic [1:0]  idx  [4];
        vals = '{{15'd0, use_3d}, lo, hi, ex};
        idx  = '{REG_THREE_D_MODE, REG_LOW_CYCLES, REG_ZERO_HIGH_CYCLES,
                 REG_EXTRA_HIGH_CYCLES};
        req_if.valid <= 1'b0;
        while (owed_line_states.size() != 0)
            @(posedge clk);
        for (int r = 0; r < 4; r++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= vals[r];
            @(posedge clk);
        end
        cfg_we    <= 1'b0;
        mode_3d   = use_3d;
        len_low   = lo;
        len_high  = hi;
        len_extra = ex;
    endtask

    // Whole frames with random content, salted with refused sends, unused ops
    // and idle ticks; retime between frames now and then.
    task automatic run_frames(input int quota);
        int stop_at;
        bit first;
        stop_at = items_in + quota;
        first   = 1'b1;
        while (items_in < stop_at) begin
            if (!first && $urandom_range(99) < 15)
                program_timing(1'($urandom), pick_len(), pick_len(), pick_len());
            first = 1'b0;
            if ($urandom_range(99) < 25)
                offer_item(random_item(2'($urandom)), 1'b0, RSP_NONE);
            offer_item(random_item($urandom_range(1) ? OP_THROTTLE : OP_COMMAND),
                       1'b0, RSP_NONE);
            while (tx_busy)
                offer_item(random_item(($urandom_range(99) < 6) ? 2'($urandom_range(1, 3))
                                                                 : OP_TICK),
                           1'b0, RSP_NONE);
        end
    endtask

    task automatic compare_field(input string name, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    // Free-running clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well past the slowest legal run
    initial begin
        #20_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Result side: check each transfer against the oldest owed line state, and
    // pick ready for the next edge (random stalls, or a long hold-off on request).
    initial begin : line_monitor
        line_state_t want;
        int          hold_left;
        hold_left    = 0;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready) begin
                if (owed_line_states.size() == 0) begin
                    fail_count++;
                    $error("result transfer with nothing owed: pin_levels %0d",
                           rsp_if.pin_levels);
                end
                else begin
                    want = owed_line_states.pop_front();
                    compare_field("pin_levels", want.pin_levels, rsp_if.pin_levels);
                    compare_field("busy_res",   want.busy_res,   rsp_if.busy_res);
                    compare_field("accepted",   want.accepted,   rsp_if.accepted);
                    compare_field("frame_done", want.frame_done, rsp_if.frame_done);
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (hold_request) begin
                // Hold off long enough for the block's queue to fill and stall req.
                hold_request = 1'b0;
                hold_left    = 80;
                rsp_if.ready <= 1'b0;
            end
            else begin
                rsp_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    // Stimulus: reset, directed table, three random stretches, then the long
    // phase-length run.
    initial begin : stimulus
        dshot_req_t it;
        // Drive every input to a known value and hold reset.
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_THREE_D_MODE;
        cfg_data          = '0;
        req_if.valid      = 1'b0;
        req_if.op         = OP_TICK;
        req_if.throttle_0 = '0;
        req_if.throttle_1 = '0;
        req_if.throttle_2 = '0;
        req_if.throttle_3 = '0;
        req_if.command    = '0;
        req_if.telemetry  = 1'b0;
        hold_request      = 1'b0;
        fail_count        = 0;
        items_in          = 0;
        frames_sent       = 0;
        sends_refused     = 0;

        // Predictor starts from the reset state of the block.
        mode_3d   = 1'b0;
        len_low   = 16'd177;
        len_high  = 16'd177;
        len_extra = 16'd177;
        for (int m = 0; m < 4; m++)
            tx_words[m] = '0;
        tx_bit   = '0;
        tx_phase = PH_LOW;
        tx_count = '0;
        tx_busy  = 1'b0;
        tx_lines = '0;

        // Sender sparse gaps, receiver stalling often
        snd_idle_pct = 17;
        rcv_idle_pct = 59;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table.
        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                program_timing(plan[r].thr0[0], plan[r].thr1, plan[r].thr2, plan[r].thr3);
            end
            else begin
                it.op        = plan[r].op;
                it.thr[0]    = plan[r].thr0;
                it.thr[1]    = plan[r].thr1;
                it.thr[2]    = plan[r].thr2;
                it.thr[3]    = plan[r].thr3;
                it.command   = plan[r].command;
                it.telemetry = plan[r].telemetry;
                repeat (plan[r].reps)
                    offer_item(it, plan[r].typed, plan[r].want);
            end
        end

        program_timing(1'b0, 16'd1, 16'd2, 16'd3);
        run_frames(50);

        // Swap the idling: sender gaps often, receiver rarely stalls.
        snd_idle_pct = 59;
        rcv_idle_pct = 17;
        program_timing(1'b1, pick_len(), pick_len(), pick_len());
        run_frames(50);

        // No idling on either side; one long receiver hold-off early on.
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        program_timing(1'($urandom), pick_len(), pick_len(), pick_len());
        hold_request = 1'b1;
        run_frames(50);

        // Longest phases: hold the low phase of the first bit for a while, then
        // shorten the phases mid-frame and finish.
        program_timing(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        offer_item(random_item(OP_THROTTLE), 1'b0, RSP_NONE);
        it = random_item(OP_TICK);
        repeat (40)
            offer_item(it, 1'b0, RSP_NONE);
        program_timing(1'b0, 16'd1, 16'd1, 16'd1);
        while (tx_busy)
            offer_item(it, 1'b0, RSP_NONE);

        // Drain, then wait for any stray results to show up.
        req_if.valid <= 1'b0;
        while (owed_line_states.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Ran %0d items: %0d frames sent to completion, %0d sends refused while busy.",
                 items_in, frames_sent, sends_refused);
        $display("Phase lengths from zero to 65535 ticks, normal and 3D throttle mapping.");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
